@@ rtl/pit_pkg.sv @@
package pit_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;
  localparam int SumW   = CrossW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } query_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } result_t;

  // edge vectors of c and b, and the vector to point p, all relative to vertex a
  typedef struct packed {
    logic signed [DiffW-1:0] v0x;
    logic signed [DiffW-1:0] v0y;
    logic signed [DiffW-1:0] v1x;
    logic signed [DiffW-1:0] v1y;
    logic signed [DiffW-1:0] v2x;
    logic signed [DiffW-1:0] v2y;
  } diff_t;

  // the six partial products of the three cross products
  typedef struct packed {
    logic signed [ProdW-1:0] k_p;
    logic signed [ProdW-1:0] k_n;
    logic signed [ProdW-1:0] a_p;
    logic signed [ProdW-1:0] a_n;
    logic signed [ProdW-1:0] b_p;
    logic signed [ProdW-1:0] b_n;
  } prod_t;

  typedef struct packed {
    logic signed [CrossW-1:0] k;
    logic signed [CrossW-1:0] a;
    logic signed [CrossW-1:0] b;
  } cross_t;

  typedef struct packed {
    logic                     degen;
    logic signed [CrossW-1:0] k;
    logic signed [CrossW-1:0] a;
    logic signed [CrossW-1:0] b;
  } norm_t;

  // handshake between pipeline stages
  typedef struct packed {
    logic valid;
  } fwd_t;

endpackage

@@ rtl/point_in_triangle_test.sv @@
// point in triangle test, barycentric form with exact integer compares
// pipeline: the result passes through five register stages
// (difference, multiply, cross subtract, orientation, compare)
// throughput: one query per cycle; each stage holds while its successor is stalled
// reset: synchronous active-high rst empties every stage; payload registers are not reset
module point_in_triangle_test
  import pit_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  output logic    query_ready,
  input  query_t  query,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  fwd_t   diff_fwd;
  fwd_t   mul_fwd;
  fwd_t   cross_fwd;
  logic   mul_ready;
  logic   cross_ready;
  logic   decide_ready;
  diff_t  diff_data;
  prod_t  prod_data;
  cross_t cross_data;

  // edge vectors
  pit_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query_valid),
    .in_ready  (query_ready),
    .in_data   (query),
    .fwd       (diff_fwd),
    .out_ready (mul_ready),
    .out_data  (diff_data)
  );

  // partial products
  pit_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_fwd    (diff_fwd),
    .in_ready  (mul_ready),
    .in_data   (diff_data),
    .fwd       (mul_fwd),
    .out_ready (cross_ready),
    .out_data  (prod_data)
  );

  // cross products
  pit_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_fwd    (mul_fwd),
    .in_ready  (cross_ready),
    .in_data   (prod_data),
    .fwd       (cross_fwd),
    .out_ready (decide_ready),
    .out_data  (cross_data)
  );

  // orientation and range compare
  pit_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_fwd    (cross_fwd),
    .in_ready  (decide_ready),
    .in_data   (cross_data),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

  // a degenerate triangle never reports inside
  a_degen_outside: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.inside_res && result.degenerate))
    else $error("degenerate triangle reported inside");

  // a free output side leaves no stage blocking the input
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> query_ready)
    else $error("query stalled while result side is ready");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

@@ rtl/pit_diff.sv @@
module pit_diff
  import pit_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  query_t in_data,
  output fwd_t   fwd,
  input  logic   out_ready,
  output diff_t  out_data
);

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign fwd.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // subtract vertex a from the other three points
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.v0x <= DiffW'(in_data.cx) - DiffW'(in_data.ax);
      out_data.v0y <= DiffW'(in_data.cy) - DiffW'(in_data.ay);
      out_data.v1x <= DiffW'(in_data.bx) - DiffW'(in_data.ax);
      out_data.v1y <= DiffW'(in_data.by) - DiffW'(in_data.ay);
      out_data.v2x <= DiffW'(in_data.px) - DiffW'(in_data.ax);
      out_data.v2y <= DiffW'(in_data.py) - DiffW'(in_data.ay);
    end
  end

endmodule

@@ rtl/pit_mul.sv @@
module pit_mul
  import pit_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  fwd_t  in_fwd,
  output logic  in_ready,
  input  diff_t in_data,
  output fwd_t  fwd,
  input  logic  out_ready,
  output prod_t out_data
);

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign fwd.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_fwd.valid;
    end
  end

  // six independent 17x17 signed products
  always_ff @(posedge clk) begin
    if (in_ready && in_fwd.valid) begin
      out_data.k_p <= in_data.v0x * in_data.v1y;
      out_data.k_n <= in_data.v0y * in_data.v1x;
      out_data.a_p <= in_data.v2x * in_data.v1y;
      out_data.a_n <= in_data.v2y * in_data.v1x;
      out_data.b_p <= in_data.v0x * in_data.v2y;
      out_data.b_n <= in_data.v0y * in_data.v2x;
    end
  end

endmodule

@@ rtl/pit_cross.sv @@
module pit_cross
  import pit_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  fwd_t   in_fwd,
  output logic   in_ready,
  input  prod_t  in_data,
  output fwd_t   fwd,
  input  logic   out_ready,
  output cross_t out_data
);

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign fwd.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_fwd.valid;
    end
  end

  // finish the cross products k = v0 x v1, a = v2 x v1, b = v0 x v2
  always_ff @(posedge clk) begin
    if (in_ready && in_fwd.valid) begin
      out_data.k <= CrossW'(in_data.k_p) - CrossW'(in_data.k_n);
      out_data.a <= CrossW'(in_data.a_p) - CrossW'(in_data.a_n);
      out_data.b <= CrossW'(in_data.b_p) - CrossW'(in_data.b_n);
    end
  end

endmodule

@@ rtl/pit_decide.sv @@
module pit_decide
  import pit_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  fwd_t    in_fwd,
  output logic    in_ready,
  input  cross_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic              nvalid;
  logic              nready;
  norm_t             norm;
  logic              neg;
  logic signed [SumW-1:0] sum_ab;
  logic signed [SumW-1:0] k_ext;

  assign nready   = !out_valid || out_ready;
  assign in_ready = !nvalid || nready;
  assign neg      = in_data.k[CrossW-1];

  // orientation stage: flip signs so that k is not negative
  always_ff @(posedge clk) begin
    if (rst) begin
      nvalid <= 1'b0;
    end else if (in_ready) begin
      nvalid <= in_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_fwd.valid) begin
      norm.degen <= (in_data.k == '0);
      norm.k     <= neg ? -in_data.k : in_data.k;
      norm.a     <= neg ? -in_data.a : in_data.a;
      norm.b     <= neg ? -in_data.b : in_data.b;
    end
  end

  // range compare, result register
  assign sum_ab = SumW'(norm.a) + SumW'(norm.b);
  assign k_ext  = SumW'(norm.k);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (nready) begin
      out_valid <= nvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (nready && nvalid) begin
      out_data.degenerate <= norm.degen;
      out_data.inside_res <= !norm.degen && !norm.a[CrossW-1] && !norm.b[CrossW-1]
                             && (sum_ab <= k_ext);
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import pit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    query_valid = 1'b0;
  logic    query_ready;
  query_t  query_word = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result_word;

  query_t  pending_queries[$];
  result_t expected_verdicts[$];
  int      error_count = 0;

  // idle control for both sides
  int      send_gap = 0;
  int      recv_stall = 0;
  logic    send_burst = 1'b0;
  logic    recv_burst = 1'b0;

  point_in_triangle_test u_top (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_ready  (query_ready),
    .query        (query_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // containment verdict from the three cross products
  function automatic result_t predict_containment(query_t q);
    longint  v0x, v0y, v1x, v1y, v2x, v2y;
    longint  k, a, b;
    result_t r;
    v0x = longint'($signed(q.cx)) - longint'($signed(q.ax));
    v0y = longint'($signed(q.cy)) - longint'($signed(q.ay));
    v1x = longint'($signed(q.bx)) - longint'($signed(q.ax));
    v1y = longint'($signed(q.by)) - longint'($signed(q.ay));
    v2x = longint'($signed(q.px)) - longint'($signed(q.ax));
    v2y = longint'($signed(q.py)) - longint'($signed(q.ay));
    k = v0x * v1y - v0y * v1x;
    a = v2x * v1y - v2y * v1x;
    b = v0x * v2y - v0y * v2x;
    r.degenerate = (k == 0);
    r.inside_res = 1'b0;
    if (k != 0) begin
      // fold orientation so that k is positive
      if (k < 0) begin
        k = -k;
        a = -a;
        b = -b;
      end
      r.inside_res = (a >= 0) && (b >= 0) && (a + b <= k);
    end
    return r;
  endfunction

  function automatic query_t make_query(int ax, int ay, int bx, int by,
                                        int cx, int cy, int px, int py);
    query_t q;
    q.ax = ax[CoordW-1:0];
    q.ay = ay[CoordW-1:0];
    q.bx = bx[CoordW-1:0];
    q.by = by[CoordW-1:0];
    q.cx = cx[CoordW-1:0];
    q.cy = cy[CoordW-1:0];
    q.px = px[CoordW-1:0];
    q.py = py[CoordW-1:0];
    return q;
  endfunction

  // append a query to the pending list
  function automatic void add_query(query_t q);
    pending_queries = {pending_queries, q};
  endfunction

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return rand_in(1, 3);
    if (r < 97) return rand_in(4, 10);
    return rand_in(20, 60);
  endfunction

  // random query, weighted toward hits, edges and degenerate shapes
  function automatic query_t random_query();
    int     ax, ay, bx, by, cx, cy, px, py;
    int     dx, dy, t, kind;
    query_t q;
    kind = $urandom_range(0, 99);
    ax = rand_in(-64, 63); ay = rand_in(-64, 63);
    bx = rand_in(-64, 63); by = rand_in(-64, 63);
    cx = rand_in(-64, 63); cy = rand_in(-64, 63);
    px = rand_in(-64, 63); py = rand_in(-64, 63);
    if (kind < 25) begin
      // full range on every bit
      q = query_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      return q;
    end else if (kind < 45) begin
      // small coordinates, plain random point
    end else if (kind < 60) begin
      // point near the centroid of a large triangle
      ax = rand_in(-32768, 32767); ay = rand_in(-32768, 32767);
      bx = rand_in(-32768, 32767); by = rand_in(-32768, 32767);
      cx = rand_in(-32768, 32767); cy = rand_in(-32768, 32767);
      px = (ax + bx + cx) / 3 + rand_in(-2, 2);
      py = (ay + by + cy) / 3 + rand_in(-2, 2);
    end else if (kind < 75) begin
      // point on or next to an edge or a vertex
      case ($urandom_range(0, 3))
        0: begin px = (ax + bx) >>> 1; py = (ay + by) >>> 1; end
        1: begin px = (bx + cx) >>> 1; py = (by + cy) >>> 1; end
        2: begin px = (ax + cx) >>> 1; py = (ay + cy) >>> 1; end
        default: begin px = cx; py = cy; end
      endcase
      px = px + rand_in(-1, 1);
      py = py + rand_in(-1, 1);
    end else if (kind < 88) begin
      // collinear or coincident vertices
      ax = rand_in(-1000, 1000); ay = rand_in(-1000, 1000);
      dx = rand_in(-100, 100);   dy = rand_in(-100, 100);
      t  = rand_in(-5, 5);
      bx = ax + dx;     by = ay + dy;
      cx = ax + t * dx; cy = ay + t * dy;
      px = ax + rand_in(-3, 3) * dx;
      py = ay + rand_in(-3, 3) * dy;
    end else begin
      // axis-aligned right triangle, point on the grid around it
      bx = ax + rand_in(1, 40); by = ay;
      cx = ax;                  cy = ay + rand_in(1, 40);
      px = rand_in(ax - 2, bx + 2);
      py = rand_in(ay - 2, cy + 2);
    end
    return make_query(ax, ay, bx, by, cx, cy, px, py);
  endfunction

  // query driver
  always @(posedge clk) begin : query_driver
    logic busy;
    if (rst) begin
      query_valid <= 1'b0;
    end else begin
      busy = query_valid;
      if (query_valid && query_ready) begin
        expected_verdicts = {expected_verdicts, predict_containment(query_word)};
        busy = 1'b0;
      end
      if ($urandom_range(0, 299) == 0) send_burst = ~send_burst;
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (pending_queries.size() > 0) begin
          query_word <= pending_queries.pop_front();
          busy = 1'b1;
          send_gap = send_burst ? 0 : pick_gap();
        end
      end
      query_valid <= busy;
    end
  end

  // result monitor and back pressure
  always @(posedge clk) begin : result_monitor
    result_t exp_word;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with no query outstanding: inside_res %0b degenerate %0b",
                 result_word.inside_res, result_word.degenerate);
          error_count++;
        end else begin
          exp_word = expected_verdicts.pop_front();
          if (result_word.inside_res !== exp_word.inside_res) begin
            $error("inside_res mismatch: expected %0b actual %0b",
                   exp_word.inside_res, result_word.inside_res);
            error_count++;
          end
          if (result_word.degenerate !== exp_word.degenerate) begin
            $error("degenerate mismatch: expected %0b actual %0b",
                   exp_word.degenerate, result_word.degenerate);
            error_count++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) recv_burst = ~recv_burst;
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        result_ready <= 1'b0;
      end else if (!recv_burst && $urandom_range(0, 3) == 0) begin
        recv_stall = pick_gap();
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    // degenerate: all vertices coincide, all zero
    add_query(make_query(0, 0, 0, 0, 0, 0, 0, 0));
    // degenerate: every field at its maximum, then at its minimum
    add_query(make_query(32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767));
    add_query(make_query(-32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768));
    // degenerate: collinear vertices, point on the line
    add_query(make_query(0, 0, 16, 16, 32, 32, 8, 8));
    // counterclockwise triangle: inside, vertex, edge, outside on each side
    add_query(make_query(0, 0, 64, 0, 0, 64, 10, 10));
    add_query(make_query(0, 0, 64, 0, 0, 64, 64, 0));
    add_query(make_query(0, 0, 64, 0, 0, 64, 32, 32));
    add_query(make_query(0, 0, 64, 0, 0, 64, 32, 0));
    add_query(make_query(0, 0, 64, 0, 0, 64, 33, 32));
    add_query(make_query(0, 0, 64, 0, 0, 64, -1, 10));
    add_query(make_query(0, 0, 64, 0, 0, 64, 10, -1));
    // same triangle with the other orientation
    add_query(make_query(0, 0, 0, 64, 64, 0, 10, 10));
    add_query(make_query(0, 0, 0, 64, 64, 0, 0, 0));
    add_query(make_query(0, 0, 0, 64, 64, 0, 40, 40));
    // full-range triangle: origin just past the long edge, point on the long edge, far corner, vertex a
    add_query(make_query(-32768, -32768, 32767, -32768,
                         -32768, 32767, 0, 0));
    add_query(make_query(-32768, -32768, 32767, -32768,
                         -32768, 32767, -1, 0));
    add_query(make_query(-32768, -32768, 32767, -32768,
                         -32768, 32767, 32767, 32767));
    add_query(make_query(-32768, -32768, 32767, -32768,
                         -32768, 32767, -32768, -32768));
    // opposite full-range triangle, clockwise
    add_query(make_query(32767, 32767, 32767, -32768,
                         -32768, 32767, 32767, 32767));
    add_query(make_query(32767, 32767, 32767, -32768,
                         -32768, 32767, -32768, -32768));
    // degenerate with a repeated vertex at the extremes
    add_query(make_query(-32768, 32767, -32768, 32767,
                         32767, -32768, 0, 0));
    // tiny triangle of one lsb
    add_query(make_query(5, 5, 6, 5, 5, 6, 5, 5));
    add_query(make_query(5, 5, 6, 5, 5, 6, 6, 6));
    repeat (1950) add_query(random_query());

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_queries.size() != 0 || query_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
